>>> design/depth_to_color_registration_assert.svh
// assertion macros shared by the registration checker
`ifndef DEPTH_TO_COLOR_REGISTRATION_ASSERT_SVH
`define DEPTH_TO_COLOR_REGISTRATION_ASSERT_SVH

// checked at every edge, also while reset is held
`define DTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define DTC_ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

>>> design/dtc_pkg.sv
// shared types, constants and reset values of the depth to color registration block
`timescale 1ns / 1ps
package dtc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam logic [63:0] DEPTH_INTR_RST = 64'd1080885901325770560;
    localparam logic [63:0] COLOR_INTR_RST = 64'd1080885901325770560;
    localparam logic [63:0] ROW_X_RST      = 64'd16384;
    localparam logic [63:0] ROW_Y_RST      = 64'd1073741824;
    localparam logic [63:0] ROW_Z_RST      = 64'd70368744177664;
    localparam logic [63:0] PROJ_OFF_RST   = 64'd0;
    localparam logic [10:0] FRAME_W_RST    = 11'd640;
    localparam logic [9:0]  FRAME_H_RST    = 10'd480;

    // half of one Q1.14 unit, for round half up
    localparam logic signed [63:0] ROT_ROUND = 64'sd8192;

    typedef enum logic [2:0] {
        CFG_DEPTH_INTR,
        CFG_COLOR_INTR,
        CFG_ROW_X,
        CFG_ROW_Y,
        CFG_ROW_Z,
        CFG_PROJ_OFF,
        CFG_FRAME_W,
        CFG_FRAME_H
    } cfg_idx_t;

    typedef enum logic [2:0] {
        GRP_ROW_X,
        GRP_ROW_Y,
        GRP_ROW_Z,
        GRP_PROJ_U,
        GRP_PROJ_V
    } mac_grp_t;

    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y,
        DIV_U,
        DIV_V
    } div_sel_t;

    typedef struct packed {
        logic     clr_step;
        logic     in_load;
        logic     pre_calc;
        logic     div_start;
        div_sel_t div_sel;
        logic     mac_start;
        logic     mac_load;
        mac_grp_t mac_grp;
        logic [1:0] mac_term;
        logic     row_store;
        logic     sc_check;
        logic     sc_write;
        logic     rd_addr;
        logic     rd_finish;
    } dtc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic skip;
        logic div_done;
        logic mac_done;
        logic zp_bad;
        logic off_frame;
    } dtc_stat_t;

endpackage

>>> design/dtc_mac.sv
// multiply-accumulate unit working through the wide operand in 16-bit chunks
`timescale 1ns / 1ps
module dtc_mac (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               load,
    input  logic signed [17:0] a,
    input  logic signed [63:0] b,
    input  logic signed [63:0] init,
    output logic signed [63:0] acc,
    output logic               done
);
    logic               busy_reg;
    logic               done_reg;
    logic [1:0]         k_reg;
    logic signed [17:0] a_reg;
    logic [63:0]        b_reg;
    logic signed [63:0] acc_reg;

    logic [15:0]        chunk;
    logic signed [16:0] chunk_s;
    logic signed [34:0] pp;
    logic signed [63:0] pp_ext;

    always_comb begin
        chunk   = b_reg[{k_reg, 4'b0000} +: 16];
        // top chunk carries the sign
        chunk_s = (k_reg == 2'd3) ? $signed({chunk[15], chunk}) : $signed({1'b0, chunk});
        pp      = a_reg * chunk_s;
        pp_ext  = 64'(pp) <<< {k_reg, 4'b0000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                k_reg    <= 2'd0;
            end else if (busy_reg) begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
            if (load) begin
                acc_reg <= init;
            end
        end else if (busy_reg) begin
            acc_reg <= acc_reg + pp_ext;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;
endmodule

>>> design/dtc_div.sv
// signed 64-bit divider, one quotient bit per cycle, quotient truncated toward zero
`timescale 1ns / 1ps
module dtc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [63:0] quo,
    output logic               done
);
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [63:0] dv_reg;
    logic        neg_reg;

    logic [64:0] rem_s;
    logic [64:0] rem_d;
    logic        ge;

    always_comb begin
        rem_s = {rem_reg, q_reg[63]};
        ge    = rem_s >= {1'b0, dv_reg};
        rem_d = rem_s - {1'b0, dv_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= 64'd0;
            q_reg   <= num[63] ? 64'(-num) : num;
            dv_reg  <= den[63] ? 64'(-den) : den;
            neg_reg <= num[63] ^ den[63];
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_d[63:0] : rem_s[63:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign done = done_reg;
endmodule

>>> design/dtc_dp.sv
// datapath: configuration registers, geometry registers, arithmetic units and frame store
`timescale 1ns / 1ps
module dtc_dp #(
    parameter int MAX_WIDTH  = dtc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtc_pkg::MAX_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dtc_pkg::dtc_cmd_t cmd,
    output dtc_pkg::dtc_stat_t stat,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic [9:0]        in_col,
    input  logic [8:0]        in_row,
    input  logic [15:0]       in_depth,
    output logic [15:0]       out_data
);
    import dtc_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int SZ_W   = $clog2(MAX_WIDTH + MAX_HEIGHT + 2048);

    logic [63:0] dint_reg, cint_reg, trx_reg, try_reg, trz_reg, poff_reg;
    logic [10:0] fw_reg;
    logic [9:0]  fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dint_reg <= DEPTH_INTR_RST;
            cint_reg <= COLOR_INTR_RST;
            trx_reg  <= ROW_X_RST;
            try_reg  <= ROW_Y_RST;
            trz_reg  <= ROW_Z_RST;
            poff_reg <= PROJ_OFF_RST;
            fw_reg   <= FRAME_W_RST;
            fh_reg   <= FRAME_H_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEPTH_INTR: dint_reg <= cfg_data;
                CFG_COLOR_INTR: cint_reg <= cfg_data;
                CFG_ROW_X:      trx_reg  <= cfg_data;
                CFG_ROW_Y:      try_reg  <= cfg_data;
                CFG_ROW_Z:      trz_reg  <= cfg_data;
                CFG_PROJ_OFF:   poff_reg <= cfg_data;
                CFG_FRAME_W:    fw_reg   <= cfg_data[10:0];
                CFG_FRAME_H:    fh_reg   <= cfg_data[9:0];
            endcase
        end
    end

    logic [15:0] dfx, dfy, dcx, dcy, cfx, cfy, ccx, ccy;
    assign dfx = dint_reg[15:0];
    assign dfy = dint_reg[31:16];
    assign dcx = dint_reg[47:32];
    assign dcy = dint_reg[63:48];
    assign cfx = cint_reg[15:0];
    assign cfy = cint_reg[31:16];
    assign ccx = cint_reg[47:32];
    assign ccy = cint_reg[63:48];

    logic signed [63:0] dtx, dty, ctx, cty;
    assign dtx = 64'($signed(poff_reg[15:0]));
    assign dty = 64'($signed(poff_reg[31:16]));
    assign ctx = 64'($signed(poff_reg[47:32]));
    assign cty = 64'($signed(poff_reg[63:48]));

    logic [SZ_W-1:0] w_eff, h_eff;
    assign w_eff = (SZ_W'(fw_reg) > SZ_W'(MAX_WIDTH))  ? SZ_W'(MAX_WIDTH)  : SZ_W'(fw_reg);
    assign h_eff = (SZ_W'(fh_reg) > SZ_W'(MAX_HEIGHT)) ? SZ_W'(MAX_HEIGHT) : SZ_W'(fh_reg);

    // input word
    logic [9:0]  col_reg;
    logic [8:0]  row_reg;
    logic [15:0] d_reg;

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            col_reg <= in_col;
            row_reg <= in_row;
            d_reg   <= in_depth;
        end
    end

    // pixel offset from principal point times depth
    logic signed [18:0] tx, ty;
    logic signed [16:0] dd;
    logic signed [35:0] pax_reg, pay_reg;

    assign tx = $signed({5'b0, col_reg, 4'b0}) - $signed({3'b0, dcx});
    assign ty = $signed({6'b0, row_reg, 4'b0}) - $signed({3'b0, dcy});
    assign dd = $signed({1'b0, d_reg});

    always_ff @(posedge aclk) begin
        if (cmd.pre_calc) begin
            pax_reg <= tx * dd;
            pay_reg <= ty * dd;
        end
    end

    logic signed [63:0] x8_reg, y8_reg, xp_reg, yp_reg, zp_reg, u_reg, v_reg;
    logic signed [63:0] z8;
    assign z8 = $signed({40'b0, d_reg, 8'b0});

    // arithmetic units
    logic signed [17:0] mac_a;
    logic signed [63:0] mac_b, mac_init, mac_acc;
    logic               mac_done;
    logic signed [63:0] div_num, div_den, div_quo;
    logic               div_done;

    function automatic logic signed [17:0] row_term(input logic [63:0] w, input logic [1:0] t);
        logic [15:0] f;
        unique case (t)
            2'd0:    f = w[15:0];
            2'd1:    f = w[31:16];
            default: f = w[47:32];
        endcase
        return 18'($signed(f));
    endfunction

    logic signed [63:0] xyz_term;
    assign xyz_term = (cmd.mac_term == 2'd0) ? x8_reg :
                      (cmd.mac_term == 2'd1) ? y8_reg : z8;

    always_comb begin
        mac_a    = '0;
        mac_b    = '0;
        mac_init = '0;
        unique case (cmd.mac_grp)
            GRP_ROW_X: begin
                mac_a    = row_term(trx_reg, cmd.mac_term);
                mac_b    = xyz_term;
                mac_init = ROT_ROUND;
            end
            GRP_ROW_Y: begin
                mac_a    = row_term(try_reg, cmd.mac_term);
                mac_b    = xyz_term;
                mac_init = ROT_ROUND;
            end
            GRP_ROW_Z: begin
                mac_a    = row_term(trz_reg, cmd.mac_term);
                mac_b    = xyz_term;
                mac_init = ROT_ROUND;
            end
            GRP_PROJ_U: begin
                mac_a    = (cmd.mac_term == 2'd0) ? $signed({2'b00, cfx})
                                                  : $signed({2'b00, ccx} + 18'd8);
                mac_b    = (cmd.mac_term == 2'd0) ? xp_reg : zp_reg;
                mac_init = ctx <<< 12;
            end
            GRP_PROJ_V: begin
                mac_a    = (cmd.mac_term == 2'd0) ? $signed({2'b00, cfy})
                                                  : $signed({2'b00, ccy} + 18'd8);
                mac_b    = (cmd.mac_term == 2'd0) ? yp_reg : zp_reg;
                mac_init = cty <<< 12;
            end
            default: begin
                mac_a    = '0;
            end
        endcase
    end

    always_comb begin
        unique case (cmd.div_sel)
            DIV_X: begin
                div_num = (64'(pax_reg) - (dtx <<< 4)) <<< 8;
                div_den = $signed({48'b0, dfx});
            end
            DIV_Y: begin
                div_num = (64'(pay_reg) - (dty <<< 4)) <<< 8;
                div_den = $signed({48'b0, dfy});
            end
            default: begin
                div_num = mac_acc;
                div_den = zp_reg <<< 4;
            end
        endcase
    end

    dtc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mac_start),
        .load    (cmd.mac_load),
        .a       (mac_a),
        .b       (mac_b),
        .init    (mac_init),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    dtc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (div_done) begin
            unique case (cmd.div_sel)
                DIV_X: x8_reg <= div_quo;
                DIV_Y: y8_reg <= div_quo;
                DIV_U: u_reg  <= div_quo;
                DIV_V: v_reg  <= div_quo;
            endcase
        end
    end

    // rotated point back to Q8 plus translation
    logic signed [63:0] row_p;
    always_comb begin
        unique case (cmd.mac_grp)
            GRP_ROW_X: row_p = (mac_acc >>> 14) + (64'($signed(trx_reg[63:48])) <<< 8);
            GRP_ROW_Y: row_p = (mac_acc >>> 14) + (64'($signed(try_reg[63:48])) <<< 8);
            default:   row_p = (mac_acc >>> 14) + (64'($signed(trz_reg[63:48])) <<< 8);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_store) begin
            unique case (cmd.mac_grp)
                GRP_ROW_X: xp_reg <= row_p;
                GRP_ROW_Y: yp_reg <= row_p;
                default:   zp_reg <= row_p;
            endcase
        end
    end

    // frame check, address and rounded depth
    logic u_ok, v_ok, rd_in;
    assign u_ok  = !u_reg[63] && (u_reg[62:0] < 63'(w_eff));
    assign v_ok  = !v_reg[63] && (v_reg[62:0] < 63'(h_eff));
    assign rd_in = (SZ_W'(col_reg) < w_eff) && (SZ_W'(row_reg) < h_eff);

    logic [CW-1:0]     col_sel;
    logic [RW-1:0]     row_sel;
    logic [ADDR_W-1:0] addr_next;
    logic signed [63:0] zr;

    assign col_sel   = cmd.sc_check ? u_reg[CW-1:0] : CW'(col_reg);
    assign row_sel   = cmd.sc_check ? v_reg[RW-1:0] : RW'(row_reg);
    assign addr_next = ADDR_W'(row_sel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_sel);
    assign zr        = zp_reg + 64'sd128;

    logic [ADDR_W-1:0] addr_reg;
    logic [15:0]       d2_reg;
    logic              rd_in_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sc_check || cmd.rd_addr) begin
            addr_reg <= addr_next;
        end
        if (cmd.sc_check) begin
            d2_reg <= (|zr[63:24]) ? 16'hFFFF : zr[23:8];
        end
        if (cmd.rd_addr) begin
            rd_in_reg <= rd_in;
        end
    end

    // clearing pass counter
    logic [ADDR_W-1:0] clr_addr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // frame store
    logic [15:0]       mem [DEPTH];
    logic [15:0]       rd_data_reg;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [15:0]       wd;

    always_comb begin
        we = 1'b0;
        wa = addr_reg;
        wd = 16'd0;
        priority if (cmd.clr_step) begin
            we = 1'b1;
            wa = clr_addr_reg;
        end else if (cmd.sc_write && (rd_data_reg == 16'd0 || rd_data_reg > d2_reg)) begin
            we = 1'b1;
            wd = d2_reg;
        end else if (cmd.rd_finish && rd_in_reg) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[addr_reg];
    end

    logic [15:0] out_reg;
    always_ff @(posedge aclk) begin
        if (cmd.rd_finish) begin
            out_reg <= rd_in_reg ? rd_data_reg : 16'd0;
        end
    end
    assign out_data = out_reg;

    assign stat.clr_last  = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign stat.skip      = (d_reg == 16'd0) || (dfx == 16'd0) || (dfy == 16'd0);
    assign stat.div_done  = div_done;
    assign stat.mac_done  = mac_done;
    assign stat.zp_bad    = zp_reg[63] || (zp_reg == 64'sd0);
    assign stat.off_frame = !(u_ok && v_ok);
endmodule

>>> design/dtc_ctrl.sv
// controller: sequences the clearing pass, reads and the scatter arithmetic
`timescale 1ns / 1ps
module dtc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               mode,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  dtc_pkg::dtc_stat_t stat,
    output dtc_pkg::dtc_cmd_t  cmd
);
    import dtc_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_RD_DONE,
        ST_PRE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MAC_GO,
        ST_MAC_WAIT,
        ST_ROW_STORE,
        ST_ZCHK,
        ST_CHECK,
        ST_SC_WAIT,
        ST_SC_WR
    } state_t;

    state_t     state_reg;
    mac_grp_t   grp_reg;
    logic [1:0] term_reg;
    div_sel_t   div_sel_reg;
    logic       m_tvalid_reg;

    logic out_free;
    logic last_term;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_term = (grp_reg == GRP_PROJ_U || grp_reg == GRP_PROJ_V) ?
                       (term_reg == 2'd1) : (term_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            grp_reg      <= GRP_ROW_X;
            term_reg     <= 2'd0;
            div_sel_reg  <= DIV_X;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (stat.clr_last) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_tvalid) state_reg <= mode ? ST_RD_ADDR : ST_PRE;
                end
                ST_RD_ADDR: state_reg <= ST_RD_WAIT;
                ST_RD_WAIT: state_reg <= ST_RD_DONE;
                ST_RD_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_PRE: begin
                    if (stat.skip) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        div_sel_reg <= DIV_X;
                        state_reg   <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (stat.div_done) begin
                        unique case (div_sel_reg)
                            DIV_X: begin
                                div_sel_reg <= DIV_Y;
                                state_reg   <= ST_DIV_GO;
                            end
                            DIV_Y: begin
                                grp_reg   <= GRP_ROW_X;
                                term_reg  <= 2'd0;
                                state_reg <= ST_MAC_GO;
                            end
                            DIV_U: begin
                                grp_reg   <= GRP_PROJ_V;
                                term_reg  <= 2'd0;
                                state_reg <= ST_MAC_GO;
                            end
                            DIV_V: state_reg <= ST_CHECK;
                        endcase
                    end
                end
                ST_MAC_GO: state_reg <= ST_MAC_WAIT;
                ST_MAC_WAIT: begin
                    if (stat.mac_done) begin
                        priority if (!last_term) begin
                            term_reg  <= term_reg + 2'd1;
                            state_reg <= ST_MAC_GO;
                        end else if (grp_reg == GRP_PROJ_U) begin
                            div_sel_reg <= DIV_U;
                            state_reg   <= ST_DIV_GO;
                        end else if (grp_reg == GRP_PROJ_V) begin
                            div_sel_reg <= DIV_V;
                            state_reg   <= ST_DIV_GO;
                        end else begin
                            state_reg <= ST_ROW_STORE;
                        end
                    end
                end
                ST_ROW_STORE: begin
                    term_reg <= 2'd0;
                    priority if (grp_reg == GRP_ROW_Z) begin
                        state_reg <= ST_ZCHK;
                    end else if (grp_reg == GRP_ROW_X) begin
                        grp_reg   <= GRP_ROW_Y;
                        state_reg <= ST_MAC_GO;
                    end else begin
                        grp_reg   <= GRP_ROW_Z;
                        state_reg <= ST_MAC_GO;
                    end
                end
                ST_ZCHK: begin
                    if (stat.zp_bad) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        grp_reg   <= GRP_PROJ_U;
                        term_reg  <= 2'd0;
                        state_reg <= ST_MAC_GO;
                    end
                end
                ST_CHECK:   state_reg <= stat.off_frame ? ST_IDLE : ST_SC_WAIT;
                ST_SC_WAIT: state_reg <= ST_SC_WR;
                ST_SC_WR:   state_reg <= ST_IDLE;
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.clr_step  = (state_reg == ST_CLEAR);
        cmd.in_load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.pre_calc  = (state_reg == ST_PRE);
        cmd.div_start = (state_reg == ST_DIV_GO);
        cmd.div_sel   = div_sel_reg;
        cmd.mac_start = (state_reg == ST_MAC_GO);
        cmd.mac_load  = (term_reg == 2'd0);
        cmd.mac_grp   = grp_reg;
        cmd.mac_term  = term_reg;
        cmd.row_store = (state_reg == ST_ROW_STORE);
        cmd.sc_check  = (state_reg == ST_CHECK);
        cmd.sc_write  = (state_reg == ST_SC_WR);
        cmd.rd_addr   = (state_reg == ST_RD_ADDR);
        cmd.rd_finish = (state_reg == ST_RD_DONE) && out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
endmodule

>>> design/depth_to_color_registration.sv
// top level of the depth to color registration block
//
// s_ channel: one word per depth pixel or per read request. s_tuser is the mode:
//   0 scatters a depth sample into the color frame store, 1 reads one stored
//   pixel, returns it on the m_ channel and clears it. Only reads give a word.
// cfg channel: register index and 64-bit data, taken at any cycle; write it
//   only while no item is in flight.
// sequence: a read passes the address and wait states to the done state,
//   which raises m_tvalid once the output register is free. A scatter runs
//   four divisions by the shared bit-serial divider and thirteen 16-bit-chunk
//   multiply-accumulates. A zero depth or zero depth focal length ends it in
//   ST_PRE, a point behind the camera in ST_ZCHK, an off-frame one in ST_CHECK.
// one item is worked at a time; s_tready is high only when the block is free.
// reset: configuration registers take their defaults, then a clearing pass
//   zeroes the frame store, one entry per cycle, over all MAX_WIDTH*MAX_HEIGHT
//   entries (524288 at the default size) with s_tready low.
// receiver stall: the result word waits in the output register; the block may
//   take the next item meanwhile, and a second read holds until the first word
//   has been taken.
`timescale 1ns / 1ps
module depth_to_color_registration #(
    parameter int MAX_WIDTH  = dtc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtc_pkg::MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // column [9:0], row [18:10], depth_raw [34:19], zero pad
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // depth_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import dtc_pkg::*;

    dtc_cmd_t  cmd;
    dtc_stat_t stat;

    // registers are always writable
    assign cfg_ready = 1'b1;

    dtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // unpack the input word straight into the datapath capture registers
    dtc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_col    (s_tdata[9:0]),
        .in_row    (s_tdata[18:10]),
        .in_depth  (s_tdata[34:19]),
        .out_data  (m_tdata)
    );
endmodule

>>> design/dtc_checker.sv
// port-level checks of the registration block, bound to the top level
`timescale 1ns / 1ps
`include "depth_to_color_registration_assert.svh"
module dtc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    // clearing pass follows every reset
    `DTC_ASSERT_ALWAYS(a_clear_after_reset, aclk, !aresetn |=> !s_tready, "ready during clear")
    `DTC_ASSERT_ALWAYS(a_out_empty_after_reset, aclk, !aresetn |=> !m_tvalid, "word after reset")
    // one item in flight at a time
    `DTC_ASSERT_RUN(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second item taken")
    `DTC_ASSERT_RUN(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "word dropped")
endmodule

bind depth_to_color_registration dtc_checker u_dtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
